// ----- hdl/line_pixel_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared concurrent assertion forms for the line pixel generator.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LPG_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define LPG_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator package
// Coordinate widths, transaction types and the queued line command.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   // coordinate width and the widths that follow from it
   localparam int COORD_BITS = 6;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ERR_BITS   = COORD_BITS + 2;

   // command queue between setup and walker
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
   } lpg_req_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } lpg_rsp_type;

   // line after setup: start point, major-axis goal, doubled deltas, initial error, directions
   typedef struct packed {
      logic [COORD_BITS-1:0]      start_x;
      logic [COORD_BITS-1:0]      start_y;
      logic [COORD_BITS-1:0]      goal_major;
      logic [DELTA_BITS-1:0]      twice_dx;
      logic [DELTA_BITS-1:0]      twice_dy;
      logic signed [ERR_BITS-1:0] err_init;
      logic                       step_x_neg;
      logic                       step_y_neg;
      logic                       x_major;
   } lpg_cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } lpg_qstat_type;

endpackage

`default_nettype wire

// ----- hdl/lpg_front.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts line transactions and works out direction, doubled deltas, major
// axis and the initial error term.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_front
   import lpg_pkg::*;
(
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire lpg_req_type   req_data,
   input  wire lpg_qstat_type q_stat,
   output logic               push,
   output lpg_cmd_type        cmd
);

   logic [COORD_BITS:0]   dx_raw;
   logic [COORD_BITS:0]   dy_raw;
   logic [COORD_BITS:0]   dx_mag;
   logic [COORD_BITS:0]   dy_mag;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  x_major;
   logic [DELTA_BITS-1:0] twice_dx;
   logic [DELTA_BITS-1:0] twice_dy;

   // hold off the requester while the queue is full
   assign req_stall = q_stat.full;
   assign push      = req_valid & ~q_stat.full;

   // signed deltas and their magnitudes
   assign dx_raw = {1'b0, req_data.end_x} - {1'b0, req_data.start_x};
   assign dy_raw = {1'b0, req_data.end_y} - {1'b0, req_data.start_y};
   assign dx_mag = dx_raw[COORD_BITS] ? (~dx_raw + 1'b1) : dx_raw;
   assign dy_mag = dy_raw[COORD_BITS] ? (~dy_raw + 1'b1) : dy_raw;
   assign adx    = dx_mag[COORD_BITS-1:0];
   assign ady    = dy_mag[COORD_BITS-1:0];

   assign twice_dx = {adx, 1'b0};
   assign twice_dy = {ady, 1'b0};
   assign x_major  = (adx >= ady);

   // build the command for the walker
   always_comb begin
      cmd.start_x    = req_data.start_x;
      cmd.start_y    = req_data.start_y;
      cmd.twice_dx   = twice_dx;
      cmd.twice_dy   = twice_dy;
      cmd.step_x_neg = dx_raw[COORD_BITS];
      cmd.step_y_neg = dy_raw[COORD_BITS];
      cmd.x_major    = x_major;
      if (x_major) begin
         cmd.goal_major = req_data.end_x;
         cmd.err_init   = $signed({1'b0, twice_dy}) - $signed({2'b00, adx});
      end else begin
         cmd.goal_major = req_data.end_y;
         cmd.err_init   = $signed({1'b0, twice_dx}) - $signed({2'b00, ady});
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lpg_queue.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// Short FIFO of set-up line commands between front end and walker.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_queue
   import lpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire lpg_cmd_type push_cmd,
   input  wire logic        pop,
   output lpg_cmd_type      head_cmd,
   output lpg_qstat_type    q_stat
);

   lpg_cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff;
   logic [QUEUE_CNT_BITS-1:0] count_in;

   assign q_stat.full      = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign head_cmd         = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lpg_walker.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator walker
// Steps one pixel per result transaction along the current line and loads
// the next queued command when idle or on the final pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_walker
   import lpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire lpg_cmd_type head_cmd,
   input  wire logic        q_not_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output lpg_rsp_type      rsp_data
);

   logic                       busy_ff;
   logic                       busy_in;
   logic [COORD_BITS-1:0]      cur_x_ff;
   logic [COORD_BITS-1:0]      cur_x_in;
   logic [COORD_BITS-1:0]      cur_y_ff;
   logic [COORD_BITS-1:0]      cur_y_in;
   logic [COORD_BITS-1:0]      goal_ff;
   logic [COORD_BITS-1:0]      goal_in;
   logic [DELTA_BITS-1:0]      tdx_ff;
   logic [DELTA_BITS-1:0]      tdx_in;
   logic [DELTA_BITS-1:0]      tdy_ff;
   logic [DELTA_BITS-1:0]      tdy_in;
   logic signed [ERR_BITS-1:0] err_ff;
   logic signed [ERR_BITS-1:0] err_in;
   logic                       sxn_ff;
   logic                       sxn_in;
   logic                       syn_ff;
   logic                       syn_in;
   logic                       xmaj_ff;
   logic                       xmaj_in;

   logic                       last;
   logic                       rsp_take;
   logic [DELTA_BITS-1:0]      t_major;
   logic [DELTA_BITS-1:0]      t_minor;
   logic                       major_neg;
   logic                       minor_step;
   logic signed [ERR_BITS-1:0] err_step;
   logic [COORD_BITS-1:0]      x_next;
   logic [COORD_BITS-1:0]      y_next;

   // present the current pixel
   assign last                = xmaj_ff ? (cur_x_ff == goal_ff) : (cur_y_ff == goal_ff);
   assign rsp_valid           = busy_ff;
   assign rsp_data.pixel_x    = cur_x_ff;
   assign rsp_data.pixel_y    = cur_y_ff;
   assign rsp_data.last_pixel = last;
   assign rsp_take            = busy_ff & ~rsp_stall;

   // load a new line when idle or when the final pixel leaves
   assign pop = q_not_empty & (~busy_ff | (rsp_take & last));

   // one Bresenham step: minor axis moves on a positive error, or on zero
   // error when the major direction is positive
   assign t_major    = xmaj_ff ? tdx_ff : tdy_ff;
   assign t_minor    = xmaj_ff ? tdy_ff : tdx_ff;
   assign major_neg  = xmaj_ff ? sxn_ff : syn_ff;
   assign minor_step = (err_ff > 0) ||
                       ((err_ff == 0) && !major_neg && (t_major != '0));
   assign err_step   = err_ff + $signed({1'b0, t_minor})
                       - (minor_step ? $signed({1'b0, t_major}) : $signed(ERR_BITS'(0)));

   always_comb begin
      x_next = cur_x_ff;
      y_next = cur_y_ff;
      if (xmaj_ff) begin
         x_next = sxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         if (minor_step && (tdy_ff != '0)) begin
            y_next = syn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
      end else begin
         y_next = syn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         if (minor_step && (tdx_ff != '0)) begin
            x_next = sxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
      end
   end

   // select load, step or hold
   always_comb begin
      busy_in  = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      goal_in  = goal_ff;
      tdx_in   = tdx_ff;
      tdy_in   = tdy_ff;
      err_in   = err_ff;
      sxn_in   = sxn_ff;
      syn_in   = syn_ff;
      xmaj_in  = xmaj_ff;
      if (pop) begin
         busy_in  = 1'b1;
         cur_x_in = head_cmd.start_x;
         cur_y_in = head_cmd.start_y;
         goal_in  = head_cmd.goal_major;
         tdx_in   = head_cmd.twice_dx;
         tdy_in   = head_cmd.twice_dy;
         err_in   = head_cmd.err_init;
         sxn_in   = head_cmd.step_x_neg;
         syn_in   = head_cmd.step_y_neg;
         xmaj_in  = head_cmd.x_major;
      end else if (rsp_take) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            cur_x_in = x_next;
            cur_y_in = y_next;
            err_in   = err_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      goal_ff  <= goal_in;
      tdx_ff   <= tdx_in;
      tdy_ff   <= tdy_in;
      err_ff   <= err_in;
      sxn_ff   <= sxn_in;
      syn_ff   <= syn_in;
      xmaj_ff  <= xmaj_in;
   end

endmodule

`default_nettype wire

// ----- hdl/line_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator
// Bresenham line rasterizer: one line in, every pixel of it out.
// ----------------------------------------------------------------------------
// Each request transaction carries a start and an end point; the block
// returns one response transaction per pixel, start point first, with
// last_pixel set on the end point. The walker produces one pixel per cycle
// while rsp_stall is low; a line yields its major-axis length plus one
// pixels (1 to 64 at six-bit coordinates), and that single step unit sets
// the sustained rate. Setup of a request is combinational, a two-entry
// command queue lets up to two further lines be accepted while the walker
// is busy, and an already queued line follows the last pixel without a gap.
`default_nettype none

module line_pixel_generator
   import lpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire lpg_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output lpg_rsp_type      rsp_data
);

   lpg_cmd_type   front_cmd;
   lpg_cmd_type   head_cmd;
   lpg_qstat_type q_stat;
   logic          push;
   logic          pop;

   lpg_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .cmd       (front_cmd)
   );

   lpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   lpg_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_not_empty (q_stat.not_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

`include "line_pixel_generator_assert.svh"

   // a pixel that is not the last one is always followed by another
   `LPG_ASSERT_NEXT(a_line_continues, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_pixel, rsp_valid, "line ended before its last pixel")

   // an idle walker picks up a queued line at once
   `LPG_ASSERT_NEXT(a_idle_loads, clock, reset, !rsp_valid && q_stat.not_empty, rsp_valid, "queued line not started")

   // an accepted request into an empty queue leaves work pending
   `LPG_ASSERT_NEXT(a_push_visible, clock, reset, push && !q_stat.not_empty, q_stat.not_empty || rsp_valid, "accepted line lost")

   // the queue never pops while empty
   `LPG_ASSERT_SAME(a_no_empty_pop, clock, reset, pop, q_stat.not_empty, "pop from empty queue")

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Line pixel generator testbench
// Sends line commands through a random-idle driver and checks each returned
// pixel against a cycle-free Bresenham predictor run at command acceptance.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import lpg_pkg::*;

   // one queued line command; wait_drain holds it back until all pixels are in
   typedef struct {
      lpg_req_type cmd;
      bit          wait_drain;
   } line_job_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   lpg_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   lpg_rsp_type rsp_data;

   line_job_type line_jobs[$];
   lpg_rsp_type  pixel_expect_q[$];
   int           lines_total;
   int           lines_taken;
   int           lines_sent;
   int           mismatches;
   bit           req_fire;
   bit           calm;

   line_pixel_generator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // walk one line and queue every pixel it should produce, start point first
   function automatic void rasterize_line(input lpg_req_type line);
      logic [COORD_BITS-1:0]      px;
      logic [COORD_BITS-1:0]      py;
      logic [COORD_BITS-1:0]      goal;
      logic [DELTA_BITS-1:0]      dbl_dx;
      logic [DELTA_BITS-1:0]      dbl_dy;
      logic signed [ERR_BITS-1:0] err;
      logic                       neg_x;
      logic                       neg_y;
      logic                       along_x;
      logic                       done;
      lpg_rsp_type                pix;
      int                         count;
      px     = line.start_x;
      py     = line.start_y;
      neg_x  = line.end_x < line.start_x;
      neg_y  = line.end_y < line.start_y;
      dbl_dx = neg_x ? (line.start_x - line.end_x) << 1 : (line.end_x - line.start_x) << 1;
      dbl_dy = neg_y ? (line.start_y - line.end_y) << 1 : (line.end_y - line.start_y) << 1;
      along_x = dbl_dx >= dbl_dy;
      if (along_x) begin
         goal = line.end_x;
         err  = $signed({1'b0, dbl_dy}) - $signed({2'b00, dbl_dx[DELTA_BITS-1:1]});
      end else begin
         goal = line.end_y;
         err  = $signed({1'b0, dbl_dx}) - $signed({2'b00, dbl_dy[DELTA_BITS-1:1]});
      end
      count = 0;
      done  = 1'b0;
      while (!done) begin
         done = ((along_x ? px : py) == goal) || (count >= 63);
         pix.pixel_x    = px;
         pix.pixel_y    = py;
         pix.last_pixel = done;
         pixel_expect_q.push_back(pix);
         count++;
         if (!done) begin
            // on a zero error the minor axis steps only for a rising major axis
            if (along_x) begin
               if (err > 0 || (err == 0 && !neg_x && dbl_dx != 0)) begin
                  err = err - $signed({1'b0, dbl_dx});
                  if (dbl_dy != 0)
                     py = neg_y ? py - 1'b1 : py + 1'b1;
               end
               err = err + $signed({1'b0, dbl_dy});
               px  = neg_x ? px - 1'b1 : px + 1'b1;
            end else begin
               if (err > 0 || (err == 0 && !neg_y && dbl_dy != 0)) begin
                  err = err - $signed({1'b0, dbl_dy});
                  if (dbl_dx != 0)
                     px = neg_x ? px - 1'b1 : px + 1'b1;
               end
               err = err + $signed({1'b0, dbl_dx});
               py  = neg_y ? py - 1'b1 : py + 1'b1;
            end
         end
      end
   endfunction

   function automatic void queue_line(input int sx, input int sy, input int ex,
                                      input int ey, input bit wait_drain);
      line_job_type job;
      job.cmd.start_x = sx[COORD_BITS-1:0];
      job.cmd.start_y = sy[COORD_BITS-1:0];
      job.cmd.end_x   = ex[COORD_BITS-1:0];
      job.cmd.end_y   = ey[COORD_BITS-1:0];
      job.wait_drain  = wait_drain;
      line_jobs.push_back(job);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0)
         return 0;
      if (v > 63)
         return 63;
      return v;
   endfunction

   // request driver: hold a stalled transaction, otherwise idle or pop the next line
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         next_valid = 1'b0;
         calm = (lines_sent >= 150) && (lines_sent < 230);
         if (line_jobs.size() != 0) begin
            if (line_jobs[0].wait_drain && pixel_expect_q.size() != 0) begin
               next_valid = 1'b0;
            end else if (!calm && $urandom_range(99) < 34) begin
               next_valid = 1'b0;
            end else begin
               req_data   <= line_jobs[0].cmd;
               line_jobs.pop_front();
               lines_sent++;
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset || calm)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 34);
   end

   // monitor: predict on accepted commands, then check accepted pixels
   always @(posedge clock) begin
      lpg_rsp_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            rasterize_line(req_data);
            lines_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_expect_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime,
                           rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.last_pixel);
               mismatches++;
            end else begin
               want = pixel_expect_q.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x || rsp_data.pixel_y !== want.pixel_y ||
                   rsp_data.last_pixel !== want.last_pixel) begin
                  if (mismatches < 10)
                     $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                              $realtime, want.pixel_x, want.pixel_y, want.last_pixel,
                              rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.last_pixel);
                  mismatches++;
               end
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int sx;
      int sy;
      int pick;
      int span;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      req_fire    = 1'b0;
      calm        = 1'b0;
      lines_taken = 0;
      lines_sent  = 0;
      mismatches  = 0;

      // directed: points, axis extremes, diagonals, zero-error ties, bit patterns
      queue_line(0, 0, 0, 0, 0);
      queue_line(63, 63, 63, 63, 0);
      queue_line(0, 0, 63, 0, 0);
      queue_line(63, 5, 0, 5, 0);
      queue_line(7, 0, 7, 63, 0);
      queue_line(9, 63, 9, 0, 0);
      queue_line(0, 0, 63, 63, 0);
      queue_line(63, 63, 0, 0, 0);
      queue_line(0, 63, 63, 0, 0);
      queue_line(63, 0, 0, 63, 0);
      queue_line(10, 10, 12, 11, 0);
      queue_line(12, 11, 10, 10, 0);
      queue_line(10, 10, 11, 12, 0);
      queue_line(11, 12, 10, 10, 0);
      queue_line(0, 0, 63, 1, 0);
      queue_line(0, 63, 1, 0, 0);
      queue_line(20, 30, 21, 30, 0);
      queue_line(42, 21, 21, 42, 0);
      queue_line(21, 42, 42, 21, 0);
      queue_line(5, 5, 6, 6, 0);
      queue_line(30, 40, 34, 38, 0);
      queue_line(34, 38, 30, 40, 0);

      // random: free lines, short lines near a point, and axis or diagonal lines
      for (int i = 0; i < 480; i++) begin
         sx   = $urandom_range(63);
         sy   = $urandom_range(63);
         pick = $urandom_range(99);
         if (pick < 45) begin
            queue_line(sx, sy, $urandom_range(63), $urandom_range(63), i == 0 || i == 400);
         end else if (pick < 85) begin
            queue_line(sx, sy, clamp_coord(sx + $urandom_range(8) - 4),
                       clamp_coord(sy + $urandom_range(8) - 4), i == 0 || i == 400);
         end else begin
            span = $urandom_range(63) - sx;
            case ($urandom_range(2))
               0: queue_line(sx, sy, sx + span, sy, i == 0 || i == 400);
               1: queue_line(sx, sy, sx, $urandom_range(63), i == 0 || i == 400);
               default: queue_line(sx, sy, sx + span,
                                   clamp_coord(sy + (($urandom_range(1) != 0) ? span : -span)),
                                   i == 0 || i == 400);
            endcase
         end
      end
      lines_total = line_jobs.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (lines_taken == lines_total);
      wait (pixel_expect_q.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pixel_expect_q.size() == 0) begin
         $display("[line_pixel_generator] OK");
      end else begin
         $display("[line_pixel_generator] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[line_pixel_generator] ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lpg_pkg.sv
hdl/lpg_front.sv
hdl/lpg_queue.sv
hdl/lpg_walker.sv
hdl/line_pixel_generator.sv
bench/tb_top.sv
